### hw/rtl/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/rw3d_pkg.sv
// ----------------------------------------------------------------------------
// rw3d_pkg
// Shared types and constants of the 3D random walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rw3d_pkg;
    localparam int SAMPLE_BITS = 16;
    localparam int POS_WIDTH   = 32;
    localparam int TRY_W       = 10;
    localparam int C_W         = SAMPLE_BITS + 2;        // signed candidate
    localparam int MAG_W       = SAMPLE_BITS + 1;        // |c| <= 2^S
    localparam int SUM_W       = 2 * SAMPLE_BITS + 3;    // sum of three squares
    localparam int ROOT_W      = SAMPLE_BITS + 2;
    localparam int NUM_W       = MAG_W + 16;             // |c| << 16
    localparam int DIV_STEPS   = NUM_W;
    localparam int SQRT_STEPS  = (SUM_W + 1) / 2;
    localparam int D_W         = 18;                     // delta, |d| <= 65536
    localparam int NLANES      = 3;
    localparam logic [TRY_W-1:0] MAX_ATT_RST = TRY_W'(1000);

    typedef enum logic [1:0] {
        ST_MOVED    = 2'd0,
        ST_RETRY    = 2'd1,
        ST_GAVE_UP  = 2'd2
    } status_t;

    typedef struct packed {
        logic             start;
        logic [ROOT_W-1:0] root;
    } lane_ctl_t;

    function automatic logic signed [POS_WIDTH-1:0] sat_add(
        input logic signed [POS_WIDTH-1:0] p,
        input logic signed [D_W-1:0]       d
    );
        logic signed [POS_WIDTH:0] v;
        logic signed [POS_WIDTH:0] hi;
        logic signed [POS_WIDTH:0] lo;
        hi = (POS_WIDTH+1)'({1'b0, {(POS_WIDTH-1){1'b1}}});
        lo = -hi - (POS_WIDTH+1)'(1);
        v  = (POS_WIDTH+1)'(p) + (POS_WIDTH+1)'(d);
        if (v > hi)
            return hi[POS_WIDTH-1:0];
        else if (v < lo)
            return lo[POS_WIDTH-1:0];
        else
            return v[POS_WIDTH-1:0];
    endfunction
endpackage

### hw/rtl/rw3d_if.sv
// ----------------------------------------------------------------------------
// rw3d_if
// Valid/ready channels of the walker: input word, result word, config word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rw3d_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [rw3d_pkg::SAMPLE_BITS-1:0]    sample_a;
    logic [rw3d_pkg::SAMPLE_BITS-1:0]    sample_b;
    logic [rw3d_pkg::SAMPLE_BITS-1:0]    sample_c;
    modport source (output valid, mode, sample_a, sample_b, sample_c, input ready);
    modport sink   (input valid, mode, sample_a, sample_b, sample_c, output ready);
endinterface

interface rw3d_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rw3d_pkg::POS_WIDTH-1:0] pos_x;
    logic signed [rw3d_pkg::POS_WIDTH-1:0] pos_y;
    logic signed [rw3d_pkg::POS_WIDTH-1:0] pos_z;
    logic [1:0]                          status;
    modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

interface rw3d_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rw3d_pkg::TRY_W-1:0]     max_attempts;
    modport source (output valid, max_attempts, input ready);
    modport sink   (input valid, max_attempts, output ready);
endinterface

### hw/rtl/rw3d_sqrt.sv
// ----------------------------------------------------------------------------
// rw3d_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rw3d_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rw3d_pkg::SUM_W-1:0]       radicand,
    output logic                             done,
    output logic [rw3d_pkg::ROOT_W-1:0]      root
);
    localparam int RW  = 2 * rw3d_pkg::SQRT_STEPS;
    localparam int CW  = $clog2(rw3d_pkg::SQRT_STEPS + 1);

    logic [RW-1:0]                 rad_reg, rad_next;
    logic [rw3d_pkg::ROOT_W+1:0]   rem_reg, rem_next;
    logic [rw3d_pkg::ROOT_W-1:0]   res_reg, res_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rw3d_pkg::ROOT_W+1:0]   trial;
    logic [rw3d_pkg::ROOT_W+1:0]   shifted;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[rw3d_pkg::ROOT_W-1:0], rad_reg[RW-1 -: 2]};
        trial     = {res_reg, 2'b01};
        if (start)
        begin
            rad_next  = RW'(radicand);
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = CW'(rw3d_pkg::SQRT_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RW-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                res_next = {res_reg[rw3d_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                res_next = {res_reg[rw3d_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule

### hw/rtl/rw3d_lane.sv
// ----------------------------------------------------------------------------
// rw3d_lane
// One axis: restoring division of |c| << 16 by the norm, sign restored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rw3d_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rw3d_pkg::lane_ctl_t                 ctl,
    input  logic signed [rw3d_pkg::C_W-1:0]     cand,
    output logic                                done,
    output logic signed [rw3d_pkg::D_W-1:0]     delta
);
    localparam int NW = rw3d_pkg::NUM_W;
    localparam int RW = rw3d_pkg::ROOT_W;
    localparam int CW = $clog2(rw3d_pkg::DIV_STEPS + 1);

    logic [NW-1:0]   num_reg, num_next;
    logic [RW:0]     rem_reg, rem_next;
    logic [RW-1:0]   den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW:0]     sh;
    logic [rw3d_pkg::MAG_W-1:0] mag;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag = cand[rw3d_pkg::C_W-1] ? rw3d_pkg::MAG_W'(-cand) : rw3d_pkg::MAG_W'(cand);
        sh  = {rem_reg[RW-1:0], num_reg[NW-1]};
        if (ctl.start)
        begin
            num_next  = {mag, 16'd0};
            rem_next  = '0;
            den_next  = ctl.root;
            neg_next  = cand[rw3d_pkg::C_W-1];
            cnt_next  = CW'(rw3d_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, den_reg})
            begin
                rem_next = sh - {1'b0, den_reg};
                num_next = {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                num_next = {num_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // quotient <= 65536 fits in D_W-1 bits
    assign done  = done_reg;
    assign delta = neg_reg ? -$signed(rw3d_pkg::D_W'(num_reg)) : $signed(rw3d_pkg::D_W'(num_reg));
endmodule

### hw/rtl/random_walk_3d_step.sv
// Lattice steps and failed tries go from accept through S_EVAL to S_OUT. Accepted
// continuous tries pass S_EVAL, S_SQRT for the bit-serial square root, whose
// done strobe loads the lanes, S_DIV for the three lane dividers running side by
// side, and the merge into S_OUT. One word in flight; a new word is taken once the
// result has left. Reset: position and failed-try count to zero, max_attempts 1000.
// ----------------------------------------------------------------------------
// random_walk_3d_step
// 3D walker with lattice moves and unit-sphere normalised continuous moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module random_walk_3d_step (
    input  logic         clk,
    input  logic         rst_n,
    rw3d_in_if.sink      in_ch,
    rw3d_out_if.source   out_ch,
    rw3d_cfg_if.sink     cfg
);
    localparam int S  = rw3d_pkg::SAMPLE_BITS;
    localparam int PW = rw3d_pkg::POS_WIDTH;
    localparam int CW = rw3d_pkg::C_W;
    localparam int TW = rw3d_pkg::TRY_W;

    typedef enum logic [2:0] { S_IDLE, S_EVAL, S_SQRT, S_DIV, S_OUT } state_t;

    state_t state_reg;
    logic signed [PW-1:0] x_reg, y_reg, z_reg;
    logic [TW-1:0] fail_reg, max_reg;
    logic [1:0]    status_reg;
    logic          mode_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [S-1:0]  ua_reg;

    logic signed [2*CW-1:0] sqx, sqy, sqz;
    logic [rw3d_pkg::SUM_W-1:0] sum_next;
    logic [rw3d_pkg::SUM_W-1:0] lim;
    logic [S+2:0]  dir_prod;
    logic [2:0]    dir;
    logic [TW-1:0] fail_inc;
    logic [TW-1:0] max_eff;
    logic          sq_start, sq_done;
    logic [rw3d_pkg::ROOT_W-1:0] root;
    rw3d_pkg::lane_ctl_t lctl;
    logic [rw3d_pkg::NLANES-1:0] ldone;
    logic signed [rw3d_pkg::D_W-1:0] dx, dy, dz;
    logic signed [rw3d_pkg::D_W-1:0] one_q, mone_q;
    logic in_fire;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign sqx = cx_reg * cx_reg;
    assign sqy = cy_reg * cy_reg;
    assign sqz = cz_reg * cz_reg;
    assign sum_next = rw3d_pkg::SUM_W'(sqx) + rw3d_pkg::SUM_W'(sqy) + rw3d_pkg::SUM_W'(sqz);
    assign lim = rw3d_pkg::SUM_W'(1) << (2 * S);
    assign dir_prod = (S+3)'(ua_reg) * (S+3)'(6);
    assign dir = dir_prod[S+2:S];
    assign fail_inc = fail_reg + TW'(1);
    assign max_eff = (max_reg == '0) ? TW'(1) : max_reg;
    assign one_q  = rw3d_pkg::D_W'(65536);
    assign mone_q = -rw3d_pkg::D_W'(65536);

    assign sq_start   = (state_reg == S_EVAL) && mode_reg
                        && (sum_next != '0) && (sum_next <= lim);
    assign lctl.start = sq_done;
    assign lctl.root  = root;

    rw3d_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_next),
        .done(sq_done), .root(root)
    );

    rw3d_lane u_lane_x (.clk(clk), .rst_n(rst_n), .ctl(lctl), .cand(cx_reg),
                        .done(ldone[0]), .delta(dx));
    rw3d_lane u_lane_y (.clk(clk), .rst_n(rst_n), .ctl(lctl), .cand(cy_reg),
                        .done(ldone[1]), .delta(dy));
    rw3d_lane u_lane_z (.clk(clk), .rst_n(rst_n), .ctl(lctl), .cand(cz_reg),
                        .done(ldone[2]), .delta(dz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            fail_reg   <= '0;
            max_reg    <= rw3d_pkg::MAX_ATT_RST;
            status_reg <= rw3d_pkg::ST_MOVED;
        end
        else
        begin
            if (cfg.valid)
                max_reg <= cfg.max_attempts;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    status_reg <= rw3d_pkg::ST_MOVED;
                    if (!mode_reg)
                    begin
                        fail_reg  <= '0;
                        state_reg <= S_OUT;
                        case (dir)
                            3'd0: x_reg <= rw3d_pkg::sat_add(x_reg, one_q);
                            3'd1: x_reg <= rw3d_pkg::sat_add(x_reg, mone_q);
                            3'd2: y_reg <= rw3d_pkg::sat_add(y_reg, one_q);
                            3'd3: y_reg <= rw3d_pkg::sat_add(y_reg, mone_q);
                            3'd4: z_reg <= rw3d_pkg::sat_add(z_reg, one_q);
                            default: z_reg <= rw3d_pkg::sat_add(z_reg, mone_q);
                        endcase
                    end
                    else if (sq_start)
                        state_reg <= S_SQRT;
                    else
                    begin
                        state_reg <= S_OUT;
                        if (fail_inc >= max_eff)
                        begin
                            fail_reg   <= '0;
                            status_reg <= rw3d_pkg::ST_GAVE_UP;
                        end
                        else
                        begin
                            fail_reg   <= fail_inc;
                            status_reg <= rw3d_pkg::ST_RETRY;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sq_done)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (&ldone)
                    begin
                        x_reg     <= rw3d_pkg::sat_add(x_reg, dx);
                        y_reg     <= rw3d_pkg::sat_add(y_reg, dy);
                        z_reg     <= rw3d_pkg::sat_add(z_reg, dz);
                        fail_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= in_ch.mode;
            ua_reg   <= in_ch.sample_a;
            cx_reg   <= $signed({1'b0, in_ch.sample_a, 1'b0}) - $signed(CW'(1) << S);
            cy_reg   <= $signed({1'b0, in_ch.sample_b, 1'b0}) - $signed(CW'(1) << S);
            cz_reg   <= $signed({1'b0, in_ch.sample_c, 1'b0}) - $signed(CW'(1) << S);
        end
    end

    assign out_ch.valid  = (state_reg == S_OUT);
    assign out_ch.pos_x  = x_reg;
    assign out_ch.pos_y  = y_reg;
    assign out_ch.pos_z  = z_reg;
    assign out_ch.status = status_reg;

    `ASSERT_IMP(a_lanes_together, clk, rst_n, ldone[0], ldone[1] && ldone[2], "lanes out of step")
    `ASSERT_NEXT(a_sqrt_to_div, clk, rst_n, sq_done, state_reg == S_DIV, "root lost")
    `ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready, "accept while busy")
    `ASSERT_IMP(a_sum_range, clk, rst_n, sq_start, sum_next <= lim, "outside sphere")
endmodule
